@@ rtl/e2q_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package e2q_pkg;

    // Field widths
    localparam int ANGLE_W  = 16;
    localparam int OUT_FRAC = 14;
    localparam int OUT_W    = OUT_FRAC + 2;

    // CORDIC datapath width (Q30 with headroom) and sine/cosine width after it
    localparam int CW   = 34;
    localparam int SC_W = 32;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [OUT_W-1:0]   quat_t;
    typedef logic signed [CW-1:0]      cordic_t;
    typedef logic signed [SC_W-1:0]    trig_t;

    // Half angle units are 1/256 degree
    localparam logic signed [ANGLE_W:0] QUARTER_TURN = 17'sd23040;
    localparam logic signed [ANGLE_W:0] HALF_TURN    = 17'sd46080;

    // pi/180 in Q38, rounding constant for the shift back to Q30
    localparam logic signed [34:0] RAD_Q38  = 35'sd4797524517;
    localparam logic signed [50:0] RAD_RND  = 51'sd32768;
    localparam int                 RAD_SHR  = 16;

    // Inverse CORDIC gain, Q30
    localparam cordic_t GAIN_INV = 34'sd652032874;

    // atan(2^-i) in Q30
    localparam logic signed [31:0] ATAN_Q30 [32] = '{
        32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
        32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
        32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
        32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
        32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
        32'sd1024,      32'sd512,       32'sd256,       32'sd128,
        32'sd64,        32'sd32,        32'sd16,        32'sd8,
        32'sd4,         32'sd2,         32'sd1,         32'sd0
    };

    // Q30 x Q30 rounding back to Q30
    localparam logic signed [63:0] Q30_RND = 64'sd1 <<< 29;
    localparam int                 Q30_SHR = 30;

    // Q60 sum to output: round, shift, clamp to +/- one
    localparam logic signed [64:0] OUT_RND = 65'sd1 <<< (59 - OUT_FRAC);
    localparam int                 OUT_SHR = 60 - OUT_FRAC;
    localparam logic signed [64:0] OUT_ONE = 65'sd1 <<< OUT_FRAC;

    function automatic quat_t round_sat(input logic signed [64:0] q60);
        logic signed [64:0] r;
        logic signed [64:0] v;
        r = q60 + OUT_RND;
        v = r >>> OUT_SHR;
        if (v > OUT_ONE) begin
            v = OUT_ONE;
        end else if (v < -OUT_ONE) begin
            v = -OUT_ONE;
        end
        return OUT_W'(v);
    endfunction

endpackage

`default_nettype wire

@@ rtl/euler_to_quaternion_top.sv @@
// Euler angles (ZYX: yaw, pitch, roll) to unit quaternion.
// Slave channel s_*: one word per orientation, three signed angles in
// degrees with 7 fraction bits. Master channel m_*: one word per input word
// holding w, x, y, z in signed Q1.14, each clamped to +/- 1.0.
// Each angle is halved, folded into a quarter turn, scaled to radians and
// rotated through one CORDIC stage per register stage, the three angles
// side by side. Two multiply stages form the pairwise and final products,
// a last stage sums, rounds and clamps.
// Throughput: one word per clock while the skid register is empty (s_tready high).
// A stall on m_tready lets one more word through into a skid register;
// after that s_tready drops until the output drains, and the whole
// pipeline holds in place, so nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline, output and skid
// registers; no state is kept between words.
`timescale 1ns / 1ps
`default_nettype none

module euler_to_quaternion_top
    import e2q_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // roll_deg, pitch_deg, yaw_deg
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata    // quat_w, quat_x, quat_y, quat_z
);

    // Stage map: 0 fold, 1 radians, 2..N+1 CORDIC, N+2 sign,
    // N+3 pair products, N+4 final products, N+5 sum and clamp
    localparam int LAST = CORDIC_STAGES + 5;

    logic [LAST:0] vld_reg;
    logic          en;

    // Fold stage
    angle_t h_next  [3];
    logic   rn_next [3];
    angle_t h_reg   [3];
    logic   rn_reg  [3];

    // Radians stage
    logic signed [50:0] rad_prod [3];
    logic signed [50:0] rad_rnd  [3];
    cordic_t            rad_next [3];

    // CORDIC stages, entry 0 is the start vector
    cordic_t cx_reg  [0:CORDIC_STAGES][0:2];
    cordic_t cy_reg  [0:CORDIC_STAGES][0:2];
    cordic_t cz_reg  [0:CORDIC_STAGES][0:2];
    logic    neg_reg [0:CORDIC_STAGES][0:2];

    // Sine / cosine, lanes 0 roll, 1 pitch, 2 yaw
    trig_t sin_reg [3];
    trig_t cos_reg [3];

    // Pair products: cycp, sysp, cysp, sycp; roll terms carried alongside
    logic signed [63:0] pp       [4];
    trig_t              pair_next [4];
    trig_t              pair_reg  [4];
    trig_t              sr_reg;
    trig_t              cr_reg;

    // Final Q60 products
    logic signed [63:0] fp_reg [8];

    // Sum, round and clamp
    quat_t quat_next [4];
    quat_t quat_reg  [4];

    // Output and skid registers
    logic [63:0] out_data_reg;
    logic        out_valid_reg;
    logic [63:0] skid_data_reg;
    logic        skid_valid_reg;
    logic [63:0] last_data;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAST-1:0], s_tvalid};
        end
    end

    // Halve (units stay), fold into a quarter turn
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [ANGLE_W:0] a;
            a = (ANGLE_W + 1)'($signed(s_tdata[k*ANGLE_W +: ANGLE_W]));
            rn_next[k] = 1'b0;
            h_next[k]  = ANGLE_W'(a);
            if (a > QUARTER_TURN) begin
                h_next[k]  = ANGLE_W'(a - HALF_TURN);
                rn_next[k] = 1'b1;
            end else if (a < -QUARTER_TURN) begin
                h_next[k]  = ANGLE_W'(a + HALF_TURN);
                rn_next[k] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_reg  <= h_next;
            rn_reg <= rn_next;
        end
    end

    // Scale to radians in Q30
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rad_prod[k] = h_reg[k] * RAD_Q38;
            rad_rnd[k]  = rad_prod[k] + RAD_RND;
            rad_next[k] = CW'(rad_rnd[k] >>> RAD_SHR);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                cx_reg[0][k]  <= GAIN_INV;
                cy_reg[0][k]  <= '0;
                cz_reg[0][k]  <= rad_next[k];
                neg_reg[0][k] <= rn_reg[k];
            end
        end
    end

    // One CORDIC rotation per stage
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        always_ff @(posedge aclk) begin
            if (en) begin
                for (int k = 0; k < 3; k++) begin
                    if (!cz_reg[i][k][CW-1]) begin
                        cx_reg[i+1][k] <= cx_reg[i][k] - (cy_reg[i][k] >>> i);
                        cy_reg[i+1][k] <= cy_reg[i][k] + (cx_reg[i][k] >>> i);
                        cz_reg[i+1][k] <= cz_reg[i][k] - CW'(ATAN_Q30[i]);
                    end else begin
                        cx_reg[i+1][k] <= cx_reg[i][k] + (cy_reg[i][k] >>> i);
                        cy_reg[i+1][k] <= cy_reg[i][k] - (cx_reg[i][k] >>> i);
                        cz_reg[i+1][k] <= cz_reg[i][k] + CW'(ATAN_Q30[i]);
                    end
                    neg_reg[i+1][k] <= neg_reg[i][k];
                end
            end
        end
    end

    // Undo the half-turn fold
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                if (neg_reg[CORDIC_STAGES][k]) begin
                    sin_reg[k] <= SC_W'(-cy_reg[CORDIC_STAGES][k]);
                    cos_reg[k] <= SC_W'(-cx_reg[CORDIC_STAGES][k]);
                end else begin
                    sin_reg[k] <= SC_W'(cy_reg[CORDIC_STAGES][k]);
                    cos_reg[k] <= SC_W'(cx_reg[CORDIC_STAGES][k]);
                end
            end
        end
    end

    // Yaw x pitch products, rounded to Q30
    always_comb begin
        pp[0] = cos_reg[2] * cos_reg[1];
        pp[1] = sin_reg[2] * sin_reg[1];
        pp[2] = cos_reg[2] * sin_reg[1];
        pp[3] = sin_reg[2] * cos_reg[1];
        for (int j = 0; j < 4; j++) begin
            pair_next[j] = SC_W'((pp[j] + Q30_RND) >>> Q30_SHR);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pair_reg <= pair_next;
            sr_reg   <= sin_reg[0];
            cr_reg   <= cos_reg[0];
        end
    end

    // Combine with roll terms, Q60
    always_ff @(posedge aclk) begin
        if (en) begin
            fp_reg[0] <= 64'(pair_reg[0]) * 64'(cr_reg);
            fp_reg[1] <= 64'(pair_reg[1]) * 64'(sr_reg);
            fp_reg[2] <= 64'(pair_reg[0]) * 64'(sr_reg);
            fp_reg[3] <= 64'(pair_reg[1]) * 64'(cr_reg);
            fp_reg[4] <= 64'(pair_reg[2]) * 64'(cr_reg);
            fp_reg[5] <= 64'(pair_reg[3]) * 64'(sr_reg);
            fp_reg[6] <= 64'(pair_reg[3]) * 64'(cr_reg);
            fp_reg[7] <= 64'(pair_reg[2]) * 64'(sr_reg);
        end
    end

    // Sum, round, clamp
    always_comb begin
        quat_next[0] = round_sat(65'(fp_reg[0]) + 65'(fp_reg[1]));
        quat_next[1] = round_sat(65'(fp_reg[2]) - 65'(fp_reg[3]));
        quat_next[2] = round_sat(65'(fp_reg[4]) + 65'(fp_reg[5]));
        quat_next[3] = round_sat(65'(fp_reg[6]) - 65'(fp_reg[7]));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quat_reg <= quat_next;
        end
    end

    assign last_data = {quat_reg[3], quat_reg[2], quat_reg[1], quat_reg[0]};

    // Output register with one-word skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && m_tready) begin
            if (skid_valid_reg) begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= vld_reg[LAST];
                out_data_reg  <= last_data;
            end
        end else if (!out_valid_reg) begin
            if (en && vld_reg[LAST]) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= last_data;
            end
        end else if (en && vld_reg[LAST]) begin
            skid_valid_reg <= 1'b1;
            skid_data_reg  <= last_data;
        end
    end

`ifndef NO_ASSERTIONS
    // Skid only fills behind a waiting output word
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without output word");

    // A word leaving the pipe into a stalled output lands in the skid
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && vld_reg[LAST] && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("word dropped at stalled output");

    // Every quaternion component stays within +/- one
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            ($signed(m_tdata[15:0])  <= 16'sd16384 && $signed(m_tdata[15:0])  >= -16'sd16384 &&
             $signed(m_tdata[31:16]) <= 16'sd16384 && $signed(m_tdata[31:16]) >= -16'sd16384 &&
             $signed(m_tdata[47:32]) <= 16'sd16384 && $signed(m_tdata[47:32]) >= -16'sd16384 &&
             $signed(m_tdata[63:48]) <= 16'sd16384 && $signed(m_tdata[63:48]) >= -16'sd16384))
        else $error("quaternion component out of range");
`endif

endmodule

`default_nettype wire
